>>> rtl/core/bms_pkg.sv
package bms_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [DATA_W-1:0] t_data;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_DRAIN
    } t_top_state;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_SEG,
        MS_HEAD,
        MS_MERGE
    } t_merge_state;

    // Memory requests from the merge engine to the two banks.
    typedef struct packed {
        logic  we;
        logic  wr_b;
        t_addr waddr;
        t_data wdata;
        logic  re;
        logic  rd_b;
        t_addr raddr;
    } t_mem_req;

    // Signed less-or-equal on raw two's complement patterns.
    function automatic logic key_le(input t_data a, input t_data b);
        return $signed(a) <= $signed(b);
    endfunction

endpackage

>>> rtl/core/bms_ram.sv
module bms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds its value while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/bms_merge.sv
module bms_merge
    import bms_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_cnt     i_count,
    input  t_data    i_rdata_a,
    input  t_data    i_rdata_b,
    output t_mem_req o_req,
    output logic     o_done,
    output logic     o_res_b
);

    t_merge_state r_state, n_state;
    t_cnt  r_n, n_n, r_w, n_w, r_lo, n_lo, r_mid, n_mid, r_hi, n_hi;
    t_cnt  r_p, n_p, r_q, n_q, r_k, n_k;
    logic  r_src_b, n_src_b, r_fwd_p, n_fwd_p, r_fwd_q, n_fwd_q, r_done, n_done;
    t_data r_a, n_a, r_b, n_b;

    t_data            rdata_src, a_eff, b_eff;
    logic             take_p, seg_last, pass_last, sort_last;
    logic [CNT_W:0]   sum_mid, sum_hi, w2;
    t_cnt             mid_c, hi_c, p_nx, q_nx;

    assign rdata_src = r_src_b ? i_rdata_b : i_rdata_a;
    // A head that was fetched in the previous cycle is taken straight from the read port.
    assign a_eff     = r_fwd_p ? rdata_src : r_a;
    assign b_eff     = r_fwd_q ? rdata_src : r_b;
    assign take_p    = (r_p < r_mid) && ((r_q >= r_hi) || key_le(a_eff, b_eff));
    assign p_nx      = t_cnt'(r_p + 1'b1);
    assign q_nx      = t_cnt'(r_q + 1'b1);
    assign seg_last  = (t_cnt'(r_k + 1'b1) == r_hi);
    assign pass_last = (r_hi == r_n);
    assign w2        = {r_w, 1'b0};
    assign sort_last = (w2 >= {1'b0, r_n});

    assign sum_mid = {1'b0, r_lo} + {1'b0, r_w};
    assign sum_hi  = {1'b0, r_lo} + w2;
    assign mid_c   = (sum_mid >= {1'b0, r_n}) ? r_n : sum_mid[CNT_W-1:0];
    assign hi_c    = (sum_hi >= {1'b0, r_n}) ? r_n : sum_hi[CNT_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            MS_IDLE: begin
                if (i_start && (i_count > t_cnt'(1))) begin
                    n_state = MS_SEG;
                end
            end
            MS_SEG:  n_state = MS_HEAD;
            MS_HEAD: n_state = MS_MERGE;
            MS_MERGE: begin
                if (seg_last) begin
                    n_state = (pass_last && sort_last) ? MS_IDLE : MS_SEG;
                end
            end
            default: n_state = MS_IDLE;
        endcase
    end

    always_comb begin
        n_n     = r_n;
        n_w     = r_w;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_p     = r_p;
        n_q     = r_q;
        n_k     = r_k;
        n_src_b = r_src_b;
        n_fwd_p = r_fwd_p;
        n_fwd_q = r_fwd_q;
        n_a     = r_a;
        n_b     = r_b;
        n_done  = 1'b0;
        case (r_state)
            MS_IDLE: begin
                if (i_start) begin
                    n_n     = i_count;
                    n_w     = t_cnt'(1);
                    n_lo    = '0;
                    n_src_b = 1'b0;
                    n_done  = (i_count <= t_cnt'(1));
                end
            end
            MS_SEG: begin
                n_mid   = mid_c;
                n_hi    = hi_c;
                n_p     = r_lo;
                n_q     = mid_c;
                n_k     = r_lo;
                n_fwd_p = 1'b0;
                n_fwd_q = 1'b0;
            end
            MS_HEAD: begin
                n_a     = rdata_src;
                n_fwd_q = 1'b1;
            end
            MS_MERGE: begin
                n_a     = a_eff;
                n_b     = b_eff;
                n_fwd_p = take_p;
                n_fwd_q = !take_p;
                n_k     = t_cnt'(r_k + 1'b1);
                if (take_p) begin
                    n_p = p_nx;
                end else begin
                    n_q = q_nx;
                end
                if (seg_last) begin
                    n_lo = r_hi;
                    if (pass_last) begin
                        n_lo    = '0;
                        n_w     = w2[CNT_W-1:0];
                        n_src_b = !r_src_b;
                        n_done  = sort_last;
                    end
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_req = '0;
        o_req.rd_b = r_src_b;
        o_req.wr_b = !r_src_b;
        case (r_state)
            MS_SEG: begin
                o_req.re    = 1'b1;
                o_req.raddr = r_lo[ADDR_W-1:0];
            end
            MS_HEAD: begin
                o_req.re    = 1'b1;
                o_req.raddr = r_q[ADDR_W-1:0];
            end
            MS_MERGE: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_k[ADDR_W-1:0];
                o_req.wdata = take_p ? a_eff : b_eff;
                o_req.re    = 1'b1;
                o_req.raddr = take_p ? p_nx[ADDR_W-1:0] : q_nx[ADDR_W-1:0];
            end
            default: begin
                o_req.re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
            r_done  <= 1'b0;
            r_src_b <= 1'b0;
            r_fwd_p <= 1'b0;
            r_fwd_q <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_src_b <= n_src_b;
            r_fwd_p <= n_fwd_p;
            r_fwd_q <= n_fwd_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_w   <= n_w;
        r_lo  <= n_lo;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_p   <= n_p;
        r_q   <= n_q;
        r_k   <= n_k;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done  = r_done;
    assign o_res_b = r_src_b;

endmodule

>>> rtl/core/block_merge_sorter_unit.sv
// Block merge sorter. Signed 32-bit values arrive one beat at a time and are
// collected in bank A until a beat with i_block_end set arrives or the 64th
// entry is written; that beat closes the block. The block is then sorted into
// ascending order by a stable bottom-up merge sort that ping-pongs between
// two single-port-read RAM banks, and the sorted values leave as a run of
// beats with o_run_end on the last one. Equal values keep their arrival order.
// The input is not ready while a block is being sorted or drained. Each
// merge pass reads the heads of a segment's two runs in turn, then writes
// one element per cycle until that segment is merged; ceil(log2(n)) passes
// are needed for a block of n elements. Draining streams one beat per cycle
// when the sink is ready.
module block_merge_sorter_unit
    import bms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_value,
    input  logic               i_block_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_sorted_value,
    output logic               o_run_end
);

    t_top_state r_state, n_state;
    t_cnt       r_count, n_count, r_ridx, n_ridx;
    logic       r_res_b, n_res_b, r_rd_pend, n_rd_pend, r_rd_last, n_rd_last;
    logic       r_ov, n_ov, r_oend, n_oend;
    t_data      r_oval, n_oval;

    t_mem_req   merge_req;
    logic       merge_done, merge_res_b, merge_start;
    t_data      rdata_a, rdata_b, rdata_res;
    t_cnt       count_nx;
    logic       in_beat, closes, can_load, consume, issue, out_last_beat;

    logic       we_a, we_b, re_a, re_b;
    t_addr      waddr_a, raddr_a, raddr_b;
    t_data      wdata_a;

    // Input side: a beat is taken only while loading.
    assign o_ready     = (r_state == ST_LOAD);
    assign in_beat     = i_valid && o_ready;
    assign count_nx    = t_cnt'(r_count + 1'b1);
    assign closes      = i_block_end || (count_nx == t_cnt'(DEPTH));
    assign merge_start = in_beat && closes;

    // Drain side: one read in flight at most; its data waits on the RAM
    // output until the output register can take it.
    assign rdata_res     = r_res_b ? rdata_b : rdata_a;
    assign can_load      = !r_ov || i_ready;
    assign consume       = r_rd_pend && can_load;
    assign issue         = (r_state == ST_DRAIN) && (r_ridx < r_count)
                           && (!r_rd_pend || consume);
    assign out_last_beat = r_ov && i_ready && r_oend;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (merge_start) begin
                    n_state = ST_SORT;
                end
            end
            ST_SORT: begin
                if (merge_done) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_last_beat) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_ridx    = r_ridx;
        n_res_b   = r_res_b;
        n_rd_pend = r_rd_pend;
        n_rd_last = r_rd_last;
        n_ov      = r_ov;
        n_oend    = r_oend;
        n_oval    = r_oval;
        case (r_state)
            ST_LOAD: begin
                if (in_beat) begin
                    n_count = count_nx;
                end
                n_ridx = '0;
            end
            ST_SORT: begin
                if (merge_done) begin
                    n_res_b = merge_res_b;
                end
            end
            ST_DRAIN: begin
                if (consume) begin
                    n_ov   = 1'b1;
                    n_oval = rdata_res;
                    n_oend = r_rd_last;
                end else if (r_ov && i_ready) begin
                    n_ov = 1'b0;
                end
                if (issue) begin
                    n_rd_pend = 1'b1;
                    n_rd_last = (t_cnt'(r_ridx + 1'b1) == r_count);
                    n_ridx    = t_cnt'(r_ridx + 1'b1);
                end else if (consume) begin
                    n_rd_pend = 1'b0;
                end
                if (out_last_beat) begin
                    n_count = '0;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    // Bank A takes the loaded values; both banks take merge writes.
    assign we_a    = in_beat || (merge_req.we && !merge_req.wr_b);
    assign waddr_a = in_beat ? r_count[ADDR_W-1:0] : merge_req.waddr;
    assign wdata_a = in_beat ? t_data'($unsigned(i_value)) : merge_req.wdata;
    assign we_b    = merge_req.we && merge_req.wr_b;

    assign re_a    = (merge_req.re && !merge_req.rd_b) || (issue && !r_res_b);
    assign re_b    = (merge_req.re && merge_req.rd_b) || (issue && r_res_b);
    assign raddr_a = (r_state == ST_SORT) ? merge_req.raddr : r_ridx[ADDR_W-1:0];
    assign raddr_b = raddr_a;

    bms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr_a),
        .i_wdata (wdata_a),
        .i_re    (re_a),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    bms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (merge_req.waddr),
        .i_wdata (merge_req.wdata),
        .i_re    (re_b),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    bms_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (merge_start),
        .i_count   (count_nx),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .o_req     (merge_req),
        .o_done    (merge_done),
        .o_res_b   (merge_res_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_ridx    <= '0;
            r_res_b   <= 1'b0;
            r_rd_pend <= 1'b0;
            r_rd_last <= 1'b0;
            r_ov      <= 1'b0;
            r_oend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ridx    <= n_ridx;
            r_res_b   <= n_res_b;
            r_rd_pend <= n_rd_pend;
            r_rd_last <= n_rd_last;
            r_ov      <= n_ov;
            r_oend    <= n_oend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oval <= n_oval;
    end

    assign o_valid        = r_ov;
    assign o_sorted_value = $signed(r_oval);
    assign o_run_end      = r_oend;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the block merge sorter. Blocks of signed values are
// pushed in one beat at a time, a software model of the sorter works out the
// sorted run that each closed block must produce, and every output beat is
// compared against the oldest value still owed by the DUT.
module tb_top
    import bms_pkg::*;
();

    // Cycles the sink refuses beats while the source keeps offering them.
    // This is long enough for a full block to load and sort, and then back up.
    localparam int LONG_HOLD    = 1200;
    // Settling time after the last expected beat, so that any straggling beat
    // is still caught.
    localparam int SETTLE       = 700;
    localparam int RANDOM_BEATS = 200;
    // Source and sink idling stop once this many random beats have gone in.
    localparam int QUIET_AFTER  = 160;
    localparam int PAUSE_AT     = 100;
    localparam int DIR_N        = 16;

    typedef struct {
        logic signed [31:0] value;
        logic               run_end;
    } t_sorted_beat;

    // One row of the directed table. A row with reps above one sends a short
    // arithmetic series, value + step * k, with block_end only on its final
    // beat. Rows with a typed result close a one-element block, whose single
    // output beat is known without any sorting.
    typedef struct packed {
        logic signed [31:0] value;
        logic               block_end;
        int                 reps;
        int                 step;
        logic               typed;
        logic signed [31:0] typed_value;
    } t_stim_row;

    localparam t_stim_row DIR_ROWS [DIR_N] = '{
        // One-element blocks at the extremes and around zero, straight after reset.
        '{32'sh7FFF_FFFF, 1'b1, 1, 0, 1'b1, 32'sh7FFF_FFFF},
        '{32'sh8000_0000, 1'b1, 1, 0, 1'b1, 32'sh8000_0000},
        '{32'sh0000_0000, 1'b1, 1, 0, 1'b1, 32'sh0000_0000},
        '{32'shFFFF_FFFF, 1'b1, 1, 0, 1'b1, 32'shFFFF_FFFF},
        // A mixed block with both extremes, a repeated value and values near
        // the sign boundary.
        '{32'sh0000_0001, 1'b0, 1, 0, 1'b0, 32'sh0},
        '{32'sh8000_0000, 1'b0, 1, 0, 1'b0, 32'sh0},
        '{32'sh7FFF_FFFF, 1'b0, 1, 0, 1'b0, 32'sh0},
        '{32'shFFFF_FFFF, 1'b0, 1, 0, 1'b0, 32'sh0},
        '{32'sh0000_0000, 1'b0, 1, 0, 1'b0, 32'sh0},
        '{32'sh0000_0001, 1'b0, 1, 0, 1'b0, 32'sh0},
        '{32'sh8000_0001, 1'b1, 1, 0, 1'b0, 32'sh0},
        // Two elements in descending order.
        '{32'sh0000_0002, 1'b0, 1, 0, 1'b0, 32'sh0},
        '{32'sh0000_0001, 1'b1, 1, 0, 1'b0, 32'sh0},
        // Already ascending, strictly descending, and all equal.
        '{32'sd10,        1'b1, 4, 1,  1'b0, 32'sh0},
        '{32'sd100,       1'b1, 4, -7, 1'b0, 32'sh0},
        '{32'sd42,        1'b1, 4, 0,  1'b0, 32'sh0}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_value;
    logic               i_block_end;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_sorted_value;
    logic               o_run_end;

    // Values of the block that is still open, in arrival order.
    logic signed [31:0] held_values[$];
    // Sorted run produced by the most recent beat, if it closed a block.
    t_sorted_beat       fresh_run[$];
    // Output beats the DUT still owes, oldest first.
    t_sorted_beat       due_beats[$];

    int   mismatch_count = 0;
    logic idle_on        = 1'b1;
    logic long_hold_req  = 1'b0;

    block_merge_sorter_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_value        (i_value),
        .i_block_end    (i_block_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sorted_value (o_sorted_value),
        .o_run_end      (o_run_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Adds one accepted value to the open block. When the beat carries
    // block_end, or when it fills the store, the block is sorted and its run
    // is left in fresh_run. The sort is a stable insertion sort: an element
    // only moves past strictly greater ones, so equal values keep their
    // arrival order just as the left run wins in the hardware merge.
    function automatic void absorb_element(input logic signed [31:0] v, input logic last);
        logic signed [31:0] key;
        int                 i;
        int                 j;
        fresh_run.delete();
        held_values.push_back(v);
        if (!last && held_values.size() < DEPTH)
            return;
        for (i = 1; i < held_values.size(); i++) begin
            key = held_values[i];
            j   = i;
            while (j > 0 && held_values[j-1] > key) begin
                held_values[j] = held_values[j-1];
                j--;
            end
            held_values[j] = key;
        end
        for (i = 0; i < held_values.size(); i++)
            fresh_run.push_back('{held_values[i], i == held_values.size() - 1});
        held_values.delete();
    endfunction

    // Random values lean on the extremes, a narrow band around zero and
    // repeats of the previous value, so that ties and sign handling come up
    // often. The rest are full-width random patterns.
    function automatic logic signed [31:0] pick_value(input logic signed [31:0] prev);
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return int'($urandom_range(0, 6)) - 3;
            3:       return prev;
            default: return $urandom;
        endcase
    endfunction

    // Mostly short blocks; now and then a medium one, or one that reaches or runs past
    // the store depth so that the 64th beat closes it, with or without block_end.
    function automatic int pick_block_len();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(64, 70);
            1:       return $urandom_range(9, 63);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    // Offers one beat and holds it until the DUT takes it. The call starts and
    // ends just after a rising edge, so every drive below is a single
    // nonblocking update for that step. A random gap may come first.
    task automatic send_beat(input logic signed [31:0] v, input logic last,
                             input logic typed, input logic signed [31:0] typed_v);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_value     <= v;
        i_block_end <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        absorb_element(v, last);
        if (typed)
            due_beats.push_back('{typed_v, 1'b1});
        else
            foreach (fresh_run[k])
                due_beats.push_back(fresh_run[k]);
    endtask

    // Drops valid and waits for every owed beat to come out. At least one
    // edge always passes, so valid is never lowered and raised in one step.
    task automatic drain_pause();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (due_beats.size() != 0);
    endtask

    initial begin : stimulus
        int                 r;
        int                 k;
        int                 sent;
        int                 len;
        logic               paused;
        logic signed [31:0] v;
        logic signed [31:0] prev;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_value     = '0;
        i_block_end = 1'b0;
        paused      = 1'b0;
        prev        = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (r = 0; r < DIR_N; r++)
            for (k = 0; k < DIR_ROWS[r].reps; k++)
                send_beat(DIR_ROWS[r].value + DIR_ROWS[r].step * k,
                          DIR_ROWS[r].block_end && (k == DIR_ROWS[r].reps - 1),
                          DIR_ROWS[r].typed, DIR_ROWS[r].typed_value);
        drain_pause();

        // Random blocks. The first one runs past the store depth while the
        // sink is held off, so the DUT sorts, cannot drain, and has to stall
        // its input with the source still offering beats.
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            if (sent == 0) begin
                long_hold_req = 1'b1;
                len = 70;
            end else begin
                len = pick_block_len();
            end
            if (sent >= PAUSE_AT && !paused) begin
                drain_pause();
                paused = 1'b1;
            end
            for (k = 0; k < len; k++) begin
                if (sent >= QUIET_AFTER)
                    idle_on = 1'b0;
                v = pick_value(prev);
                send_beat(v, k == len - 1, 1'b0, 32'sh0);
                prev = v;
                sent++;
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (due_beats.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && due_beats.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Sink pacing. Ready is changed once per edge: a held-off stretch on
    // request, random stall bursts between ready runs while idling is on, and
    // ready held high for the quiet end of the run.
    initial begin : sink_pacing
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        i_ready    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!idle_on || run_left > 0) begin
                if (run_left > 0)
                    run_left--;
                i_ready <= 1'b1;
            end else begin
                // This cycle is the first of the stall burst.
                stall_left = $urandom_range(0, 13);
                run_left   = $urandom_range(1, 24);
                i_ready    <= 1'b0;
            end
        end
    end

    // Output checker. Values are read right after the edge, before any
    // nonblocking update of that step lands, so they are the ones the edge
    // saw.
    always @(posedge i_clk) begin : check_beats
        t_sorted_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual value %0d run_end %0b",
                         $time, o_sorted_value, o_run_end);
                mismatch_count++;
            end else begin
                want = due_beats.pop_front();
                if (o_sorted_value !== want.value) begin
                    $display("%0t: sorted_value expected %0d actual %0d",
                             $time, want.value, o_sorted_value);
                    mismatch_count++;
                end
                if (o_run_end !== want.run_end) begin
                    $display("%0t: run_end expected %0b actual %0b",
                             $time, want.run_end, o_run_end);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog. A correct run with every gap and stall at its longest ends well
    // before this limit.
    initial begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
